>>> src/md5v_pkg.sv
// package for the md5 variant digest engine: states, round tables and helpers
`default_nettype none

package md5v_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MARK,
    S_FILL,
    S_LOAD,
    S_ROUND,
    S_FOLD,
    S_OUT0,
    S_OUT1
  } state_t;

  typedef logic [31:0] word_t;

  localparam word_t H_INIT [4] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476
  };

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [3:0] LEN_LO_WORD = 4'd14;
  localparam logic [3:0] LEN_HI_WORD = 4'd15;
  localparam logic [3:0] LAST_WORD   = 4'd15;

  localparam word_t ROUND_ADD [64] = '{
    32'hD74AA478, 32'hE3CEB456, 32'h2420B0DB, 32'h212AC5EE,
    32'h325C6CAF, 32'h4785B22A, 32'h48346C63, 32'hF2485501,
    32'h3980C258, 32'h834412AF, 32'h3DCF65B1, 32'h831CD76E,
    32'h6B605552, 32'hFD937193, 32'hA669B38E, 32'h44C43821,
    32'h341E2562, 32'hC0EAB340, 32'h265B3A51, 32'hE9B6C7AA,
    32'hD62F132D, 32'h2541B435, 32'hD8A1E681, 32'h37B3FBC8,
    32'h21E1C3E6, 32'hC33707D6, 32'hFBD50D87, 32'h455A34ED,
    32'hA9E38905, 32'h8CE3A3F8, 32'h676F82D9, 32'hBD234B8A,
    32'h32FA3942, 32'h87E1F681, 32'h6D3D6122, 32'hFDE2A80C,
    32'hA4B4EA14, 32'h4A7ECFA9, 32'hFB6B46B0, 32'hBE7FBC70,
    32'h289E75C6, 32'hE33127FA, 32'hD4E73E85, 32'h4881D075,
    32'hD9BED539, 32'hE6DB97E5, 32'hEFA27CF8, 32'hCFA55665,
    32'h14292244, 32'h4A2AFF97, 32'hABE223A7, 32'hFC93A039,
    32'h25B1663C, 32'h8F0CCC92, 32'h4F4FF47D, 32'h85845DD1,
    32'h61A57E4F, 32'h6E2CE6E0, 32'hA0313414, 32'h4E0711A1,
    32'hF8537E82, 32'hBD38F235, 32'h8AD7D2BB, 32'hEB868991
  };

  localparam logic [4:0] ROT_AMT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // message word index used by a round
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] q;
    logic [3:0] g;
    q = rnd[3:0];
    unique case (rnd[5:4])
      2'd0:    g = q;
      2'd1:    g = 4'd1 + q * 4'd5;
      2'd2:    g = 4'd5 + q * 4'd3;
      default: g = q * 4'd7;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

>>> src/md5_variant_digest.sv
// md5 variant digest engine: word packing, padding, block buffer memory and round unit
`default_nettype none

// Takes one little-endian message word per handshake with a byte count and a last flag,
// and after the last word returns the 128-bit digest as two 64-bit halves, then clears
// itself for the next message. Each time a 64-byte block fills, the engine stops taking
// words while it prefetches from the block buffer memory, the single round unit does one
// round of the MD5 variant per cycle with its message word read from that memory, and
// the result is folded into the chaining words. After the last word, padding writes up
// to 16 buffer words per block at one per cycle and runs one or two more block
// compressions, and the two digest halves follow, one per accepted output.
module md5_variant_digest (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_message_word,
  input  wire logic [2:0]  in_valid_bytes,
  input  wire logic        in_last_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_digest_half,
  output logic             out_half_index,
  output logic             out_last_half
);

  md5v_pkg::state_t state_r, state_nxt;

  logic [5:0]  rnd_r, rnd_nxt;
  logic [3:0]  wi_r, wi_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [63:0] bitlen_r, bitlen_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        last_r, last_nxt;
  logic        pad_r, pad_nxt;
  logic        lenok_r, lenok_nxt;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt;
  logic [31:0] h_r [4];
  logic [31:0] h_nxt [4];

  logic [31:0] mem [16];
  logic [31:0] rdata_r;
  logic        mem_we;
  logic [3:0]  mem_wa;
  logic [31:0] mem_wd;
  logic [3:0]  rd_addr;

  logic [2:0]  count;
  logic [1:0]  k;
  logic [2:0]  total;
  logic [31:0] acc_m;
  logic [63:0] comb_w;
  logic [31:0] mark_w;
  logic [31:0] f;
  logic [31:0] t1;
  logic [63:0] rot64;
  logic [31:0] t2;
  logic [5:0]  rnd_inc;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= md5v_pkg::S_IDLE;
      rnd_r    <= '0;
      wi_r     <= '0;
      pos_r    <= '0;
      bitlen_r <= '0;
      last_r   <= 1'b0;
      pad_r    <= 1'b0;
      lenok_r  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        h_r[i] <= md5v_pkg::H_INIT[i];
      end
    end else begin
      state_r  <= state_nxt;
      rnd_r    <= rnd_nxt;
      wi_r     <= wi_nxt;
      pos_r    <= pos_nxt;
      bitlen_r <= bitlen_nxt;
      last_r   <= last_nxt;
      pad_r    <= pad_nxt;
      lenok_r  <= lenok_nxt;
      for (int i = 0; i < 4; i++) begin
        h_r[i] <= h_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
  end

  // byte packing
  always_comb begin
    count = (in_valid_bytes > 3'd4) ? 3'd4 : in_valid_bytes;
    k     = pos_r[1:0];
    total = {1'b0, k} + count;
    unique case (k)
      2'd0:    acc_m = 32'h0;
      2'd1:    acc_m = {24'h0, acc_r[7:0]};
      2'd2:    acc_m = {16'h0, acc_r[15:0]};
      default: acc_m = {8'h0, acc_r[23:0]};
    endcase
    comb_w = {32'h0, acc_m} | ({32'h0, in_message_word} << {k, 3'b000});
    mark_w = acc_m | ({24'h0, md5v_pkg::PAD_MARK} << {k, 3'b000});
  end

  // round unit
  always_comb begin
    unique case (rnd_r[5:4])
      2'd0:    f = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f = (b_r & d_r) | (c_r & ~d_r);
      2'd2:    f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    t1      = a_r + f + rdata_r + md5v_pkg::ROUND_ADD[rnd_r];
    rot64   = {t1, t1} << md5v_pkg::ROT_AMT[{rnd_r[5:4], rnd_r[1:0]}];
    t2      = b_r + rot64[63:32];
    rnd_inc = rnd_r + 6'd1;
  end

  always_comb begin
    state_nxt  = state_r;
    rnd_nxt    = rnd_r;
    wi_nxt     = wi_r;
    pos_nxt    = pos_r;
    bitlen_nxt = bitlen_r;
    acc_nxt    = acc_r;
    last_nxt   = last_r;
    pad_nxt    = pad_r;
    lenok_nxt  = lenok_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    c_nxt      = c_r;
    d_nxt      = d_r;
    for (int i = 0; i < 4; i++) begin
      h_nxt[i] = h_r[i];
    end
    mem_we    = 1'b0;
    mem_wa    = pos_r[5:2];
    mem_wd    = comb_w[31:0];
    rd_addr   = md5v_pkg::msg_index(6'd0);
    in_ready  = 1'b0;
    out_valid = 1'b0;

    unique case (state_r)
      md5v_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          bitlen_nxt = bitlen_r + {58'h0, count, 3'b000};
          pos_nxt    = pos_r + {3'b000, count};
          last_nxt   = in_last_word;
          if (total[2]) begin
            mem_we  = 1'b1;
            acc_nxt = comb_w[63:32];
          end else begin
            acc_nxt = comb_w[31:0];
          end
          if (total[2] && (pos_r[5:2] == md5v_pkg::LAST_WORD)) begin
            state_nxt = md5v_pkg::S_LOAD;
          end else if (in_last_word) begin
            state_nxt = md5v_pkg::S_MARK;
          end
        end
      end
      md5v_pkg::S_MARK: begin
        mem_we  = 1'b1;
        mem_wd  = mark_w;
        pad_nxt = 1'b1;
        if (pos_r[5:2] == md5v_pkg::LAST_WORD) begin
          lenok_nxt = 1'b0;
          state_nxt = md5v_pkg::S_LOAD;
        end else begin
          wi_nxt    = pos_r[5:2] + 4'd1;
          lenok_nxt = (pos_r[5:2] != md5v_pkg::LEN_LO_WORD);
          state_nxt = md5v_pkg::S_FILL;
        end
      end
      md5v_pkg::S_FILL: begin
        mem_we = 1'b1;
        mem_wa = wi_r;
        if (lenok_r && (wi_r == md5v_pkg::LEN_LO_WORD)) begin
          mem_wd = bitlen_r[31:0];
        end else if (lenok_r && (wi_r == md5v_pkg::LEN_HI_WORD)) begin
          mem_wd = bitlen_r[63:32];
        end else begin
          mem_wd = 32'h0;
        end
        if (wi_r == md5v_pkg::LAST_WORD) begin
          state_nxt = md5v_pkg::S_LOAD;
        end else begin
          wi_nxt = wi_r + 4'd1;
        end
      end
      md5v_pkg::S_LOAD: begin
        rd_addr   = md5v_pkg::msg_index(6'd0);
        a_nxt     = h_r[0];
        b_nxt     = h_r[1];
        c_nxt     = h_r[2];
        d_nxt     = h_r[3];
        rnd_nxt   = 6'd0;
        state_nxt = md5v_pkg::S_ROUND;
      end
      md5v_pkg::S_ROUND: begin
        rd_addr = md5v_pkg::msg_index(rnd_inc);
        a_nxt   = d_r;
        d_nxt   = c_r;
        c_nxt   = b_r;
        b_nxt   = t2;
        rnd_nxt = rnd_inc;
        if (rnd_r == 6'd63) begin
          state_nxt = md5v_pkg::S_FOLD;
        end
      end
      md5v_pkg::S_FOLD: begin
        h_nxt[0] = h_r[0] + a_r;
        h_nxt[1] = h_r[1] + b_r;
        h_nxt[2] = h_r[2] + c_r;
        h_nxt[3] = h_r[3] + d_r;
        priority if (!pad_r) begin
          state_nxt = last_r ? md5v_pkg::S_MARK : md5v_pkg::S_IDLE;
        end else if (lenok_r) begin
          state_nxt = md5v_pkg::S_OUT0;
        end else begin
          wi_nxt    = 4'd0;
          lenok_nxt = 1'b1;
          state_nxt = md5v_pkg::S_FILL;
        end
      end
      md5v_pkg::S_OUT0: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = md5v_pkg::S_OUT1;
        end
      end
      md5v_pkg::S_OUT1: begin
        out_valid = 1'b1;
        if (out_ready) begin
          for (int i = 0; i < 4; i++) begin
            h_nxt[i] = md5v_pkg::H_INIT[i];
          end
          bitlen_nxt = '0;
          pos_nxt    = '0;
          pad_nxt    = 1'b0;
          last_nxt   = 1'b0;
          state_nxt  = md5v_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = md5v_pkg::S_IDLE;
      end
    endcase
  end

  assign out_half_index  = (state_r == md5v_pkg::S_OUT1);
  assign out_last_half   = (state_r == md5v_pkg::S_OUT1);
  assign out_digest_half = (state_r == md5v_pkg::S_OUT1) ? {h_r[3], h_r[2]}
                                                          : {h_r[1], h_r[0]};

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output open together");

  a_fold_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == md5v_pkg::S_FOLD) |->
      $past(state_r == md5v_pkg::S_ROUND && rnd_r == 6'd63))
    else $error("fold without a full set of rounds");

  a_no_write_in_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == md5v_pkg::S_LOAD || state_r == md5v_pkg::S_ROUND) |-> !mem_we)
    else $error("block buffer written during compression");

  a_second_half: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_half_index) |=> (out_valid && out_half_index))
    else $error("second digest half missing");

endmodule

`default_nettype wire

>>> test/tb_md5_variant_digest.sv
// testbench for md5_variant_digest: random and edge-case messages checked against a digest predictor
module tb_md5_variant_digest;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;
  localparam int WORD_TARGET = 800;
  localparam int IDLE_PCT    = 34;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_WAIT  = 300;

  localparam logic [31:0] CHAIN_IV [4] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476
  };

  localparam logic [31:0] ADD_TAB [64] = '{
    32'hD74AA478, 32'hE3CEB456, 32'h2420B0DB, 32'h212AC5EE,
    32'h325C6CAF, 32'h4785B22A, 32'h48346C63, 32'hF2485501,
    32'h3980C258, 32'h834412AF, 32'h3DCF65B1, 32'h831CD76E,
    32'h6B605552, 32'hFD937193, 32'hA669B38E, 32'h44C43821,
    32'h341E2562, 32'hC0EAB340, 32'h265B3A51, 32'hE9B6C7AA,
    32'hD62F132D, 32'h2541B435, 32'hD8A1E681, 32'h37B3FBC8,
    32'h21E1C3E6, 32'hC33707D6, 32'hFBD50D87, 32'h455A34ED,
    32'hA9E38905, 32'h8CE3A3F8, 32'h676F82D9, 32'hBD234B8A,
    32'h32FA3942, 32'h87E1F681, 32'h6D3D6122, 32'hFDE2A80C,
    32'hA4B4EA14, 32'h4A7ECFA9, 32'hFB6B46B0, 32'hBE7FBC70,
    32'h289E75C6, 32'hE33127FA, 32'hD4E73E85, 32'h4881D075,
    32'hD9BED539, 32'hE6DB97E5, 32'hEFA27CF8, 32'hCFA55665,
    32'h14292244, 32'h4A2AFF97, 32'hABE223A7, 32'hFC93A039,
    32'h25B1663C, 32'h8F0CCC92, 32'h4F4FF47D, 32'h85845DD1,
    32'h61A57E4F, 32'h6E2CE6E0, 32'hA0313414, 32'h4E0711A1,
    32'hF8537E82, 32'hBD38F235, 32'h8AD7D2BB, 32'hEB868991
  };

  localparam int ROT_TAB [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  typedef struct packed {
    logic [63:0] half;
    logic        idx;
    logic        is_last;
  } digest_half_t;

  class digest_scoreboard;
    logic [31:0]  chain [4];
    logic [31:0]  blk [16];
    logic [63:0]  nbits;
    logic [5:0]   pos;
    digest_half_t due_halves [$];
    int           mismatches;
    int           halves_seen;
    int           halves_ok;
    int           messages;

    function new();
      foreach (blk[i]) blk[i] = '0;
      mismatches  = 0;
      halves_seen = 0;
      halves_ok   = 0;
      messages    = 0;
      restart();
    endfunction

    function void restart();
      foreach (chain[i]) chain[i] = CHAIN_IV[i];
      nbits = '0;
      pos   = '0;
    endfunction

    function void mix_block();
      logic [31:0] a, b, c, d, f, t;
      int g;
      int sh;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int r = 0; r < 64; r++) begin
        case (r / 16)
          0: begin
            f = (b & c) | (~b & d);
            g = r;
          end
          1: begin
            f = (b & d) | (c & ~d);
            g = (1 + 5 * r) % 16;
          end
          2: begin
            f = b ^ c ^ d;
            g = (5 + 3 * r) % 16;
          end
          default: begin
            f = c ^ (b | ~d);
            g = (7 * r) % 16;
          end
        endcase
        t  = a + f + blk[g] + ADD_TAB[r];
        sh = ROT_TAB[(r / 16) * 4 + r % 4];
        t  = b + ((t << sh) | (t >> (32 - sh)));
        a  = d;
        d  = c;
        c  = b;
        b  = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
    endfunction

    function void absorb_byte(input logic [7:0] v);
      blk[pos[5:2]][pos[1:0] * 8 +: 8] = v;
      pos = pos + 6'd1;
      if (pos == 6'd0) mix_block();
    endfunction

    function void note_word(input logic [31:0] w, input logic [2:0] n, input logic l);
      int cnt;
      logic [63:0] len;
      digest_half_t h;
      cnt = (n > 3'd4) ? 4 : int'(n);
      for (int i = 0; i < cnt; i++) begin
        absorb_byte(w[8 * i +: 8]);
        nbits += 64'd8;
      end
      if (!l) return;
      len = nbits;
      absorb_byte(8'h80);
      while (pos != 6'd56) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(len[8 * i +: 8]);
      h.half    = {chain[1], chain[0]};
      h.idx     = 1'b0;
      h.is_last = 1'b0;
      due_halves.push_back(h);
      h.half    = {chain[3], chain[2]};
      h.idx     = 1'b1;
      h.is_last = 1'b1;
      due_halves.push_back(h);
      messages++;
      restart();
    endfunction

    function void check_half(input logic [63:0] half, input logic idx, input logic is_last);
      digest_half_t want;
      halves_seen++;
      if (due_halves.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("digest half with nothing pending: %h idx %0d last %0d", half, idx, is_last);
        return;
      end
      want = due_halves.pop_front();
      if (want.half !== half || want.idx !== idx || want.is_last !== is_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("digest half mismatch: expected %h idx %0d last %0d, got %h idx %0d last %0d",
                   want.half, want.idx, want.is_last, half, idx, is_last);
      end else begin
        halves_ok++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_message_word;
  logic [2:0]  in_valid_bytes;
  logic        in_last_word;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_digest_half;
  logic        out_half_index;
  logic        out_last_half;

  digest_scoreboard sb = new();
  int cycle_count = 0;
  int words_sent  = 0;
  int empties     = 0;
  bit idle_on     = 1'b1;

  always #1ns clk = ~clk;

  md5_variant_digest u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_message_word (in_message_word),
    .in_valid_bytes  (in_valid_bytes),
    .in_last_word    (in_last_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_half (out_digest_half),
    .out_half_index  (out_half_index),
    .out_last_half   (out_last_half)
  );

  task automatic send_word(input logic [31:0] w, input logic [2:0] n, input logic l);
    in_valid        <= 1'b1;
    in_message_word <= w;
    in_valid_bytes  <= n;
    in_last_word    <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(w, n, l);
    if (n != 3'd0 || l) words_sent++;
    else empties++;
    if (idle_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic send_message(input int full_words, input int tail, input bit noisy);
    logic [2:0] n;
    for (int i = 0; i < full_words; i++) begin
      if (noisy && $urandom_range(9) == 0) send_word($urandom, 3'd0, 1'b0);
      n = ($urandom_range(7) == 0) ? 3'($urandom_range(7, 5)) : 3'd4;
      send_word($urandom, n, 1'b0);
    end
    n = 3'(tail);
    if (tail == 4 && $urandom_range(3) == 0) n = 3'($urandom_range(7, 5));
    send_word($urandom, n, 1'b1);
  endtask

  task automatic wait_all_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_halves.size() != 0) @(posedge clk);
  endtask

  initial begin : result_sink
    int hold_left;
    bit hold_done;
    bit rdy;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_half(out_digest_half, out_half_index, out_last_half);
      if (!hold_done && sb.halves_seen >= 40) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (sb.halves_seen >= 80 && sb.halves_seen < 120) begin
        rdy = 1'b1;
      end else begin
        rdy = ($urandom_range(99) >= IDLE_PCT);
      end
      out_ready <= rdy;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d digest halves pending", cycle_count,
             sb.due_halves.size());
    $display("md5_variant_digest verification failed");
    $finish;
  end

  initial begin : stimulus
    int fw;
    int pick;
    int msg_count;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_message_word <= '0;
    in_valid_bytes  <= '0;
    in_last_word    <= 1'b0;
    msg_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty message, then short messages with extreme words and every byte count
    send_word(32'h00000000, 3'd0, 1'b1);
    send_word(32'hFFFFFFFF, 3'd4, 1'b0);
    send_word(32'h00000000, 3'd4, 1'b0);
    send_word(32'hA5A5A5A5, 3'd0, 1'b0);
    send_word(32'h5A5A5A5A, 3'd3, 1'b1);
    send_word(32'h12345678, 3'd7, 1'b0);
    send_word(32'h87654321, 3'd5, 1'b0);
    send_word(32'hFFFFFFFF, 3'd6, 1'b1);
    send_word(32'hDEADBEEF, 3'd1, 1'b1);
    send_word(32'hCAFEF00D, 3'd2, 1'b1);
    send_word(32'h00000000, 3'd4, 1'b1);
    send_word(32'hFFFFFFFF, 3'd4, 1'b1);
    send_word(32'h0F0F0F0F, 3'd4, 1'b0);
    send_word(32'hFFFFFFFF, 3'd0, 1'b1);
    wait_all_done();

    // padding edges around one block
    send_message(13, 3, 1'b0);
    send_message(13, 4, 1'b0);
    send_message(14, 0, 1'b0);
    send_message(15, 3, 1'b0);
    send_message(16, 0, 1'b0);

    while (words_sent < WORD_TARGET) begin
      idle_on = !(words_sent >= 300 && words_sent < 450);
      pick = $urandom_range(9);
      if (pick < 5) fw = $urandom_range(6);
      else if (pick < 7) fw = $urandom_range(16, 12);
      else if (pick == 7) fw = $urandom_range(32, 28);
      else if (pick == 8) fw = $urandom_range(20);
      else fw = $urandom_range(40, 33);
      send_message(fw, $urandom_range(4), 1'b1);
      msg_count++;
      if (msg_count == 30) wait_all_done();
    end
    wait_all_done();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d messages in %0d words plus %0d ignored empty words",
             sb.messages, words_sent, empties);
    $display("%0d digest halves matched, %0d mismatched, %0d still pending",
             sb.halves_ok, sb.mismatches, sb.due_halves.size());
    if (sb.mismatches == 0 && sb.due_halves.size() == 0) begin
      $display("md5_variant_digest verification clean");
    end else begin
      $display("md5_variant_digest verification failed");
    end
    $finish;
  end

endmodule
